FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while reset is released
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// shared types, codes, constants and constant-divisor helpers of the tracker
// ----------------------------------------------------------------------------
package pst_pkg;

    // op codes
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_SYNC  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DEVICE_PRESENT = 2'd0;
    localparam logic [1:0] REG_STALE_LIMIT    = 2'd1;
    localparam logic [1:0] REG_MIN_GAP        = 2'd2;
    localparam logic [1:0] REG_MAX_GAP        = 2'd3;

    localparam logic [15:0] STALE_LIMIT_RESET = 16'd3000;
    localparam logic [15:0] MIN_GAP_RESET     = 16'd500;
    localparam logic [15:0] MAX_GAP_RESET     = 16'd1500;

    localparam logic [4:0]  RESYNC_LAST      = 5'd29;   // resync period 30, minus one
    localparam logic [9:0]  PHASE_CLAMP      = 10'd999;
    localparam logic [31:0] FALLBACK_SECONDS = 32'd946684800;

    // exact floor reciprocals for 32-bit dividends
    localparam logic [28:0] RECIP_1000 = 29'd274877907;  // ceil(2^38 / 1000)
    localparam int          SHIFT_1000 = 38;
    localparam logic [31:0] RECIP_30   = 32'd2290649225; // ceil(2^36 / 30)
    localparam int          SHIFT_30   = 36;

    typedef struct packed {
        logic        device_present;
        logic [15:0] stale_limit_ms;
        logic [15:0] min_gap_ms;
        logic [15:0] max_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [7:0]  pulse_count;
        logic [31:0] edge_ms;
        logic [31:0] chip_seconds;
        logic        edge_moved;
        logic [9:0]  now_mod1000;
        logic [4:0]  chip_mod30;
    } t_item;

    typedef struct packed {
        logic        tick_valid;
        logic [31:0] tick_seconds;
        logic [31:0] tick_edge_ms;
        logic        discontinuity;
        logic [9:0]  phase_ms;
        logic        healthy;
        logic [31:0] current_seconds;
    } t_result;

    // x mod 1000 by reciprocal multiply and a shift-add back-multiply
    function automatic logic [9:0] mod1000(input logic [31:0] x);
        logic [60:0] prod;
        logic [22:0] q;
        logic [31:0] r;
        prod = 61'(x) * 61'(RECIP_1000);
        q    = prod[SHIFT_1000 +: 23];
        // q * 1000 = q * 1024 - q * 16 - q * 8
        r    = x - 32'({q, 10'd0}) + 32'({q, 4'd0}) + 32'({q, 3'd0});
        return r[9:0];
    endfunction

    // x mod 30
    function automatic logic [4:0] mod30(input logic [31:0] x);
        logic [63:0] prod;
        logic [27:0] q;
        logic [31:0] r;
        prod = 64'(x) * 64'(RECIP_30);
        q    = prod[SHIFT_30 +: 28];
        // q * 30 = q * 32 - q * 2
        r    = x - 32'({q, 5'd0}) + 32'({q, 1'd0});
        return r[4:0];
    endfunction

endpackage

FILE: rtl/pst_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_engine
// tracker state and the per-beat update and status logic
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pst_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  pst_pkg::t_cfg   i_cfg,
    input  pst_pkg::t_item  i_item,
    output pst_pkg::t_result o_res
);

    logic [31:0] r_cached_seconds, n_cached_seconds;
    logic [4:0]  r_cached_mod30,   n_cached_mod30;
    logic        r_cache_valid,    n_cache_valid;
    logic        r_resync_pending, n_resync_pending;
    logic        r_saw_edge,       n_saw_edge;
    logic [31:0] r_last_edge_ms,   n_last_edge_ms;
    logic [31:0] r_start_ms,       n_start_ms;
    logic        r_started,        n_started;

    logic [31:0] stale32, d_edge, d_last, d_start, gap, expected, d_ref, elapsed;
    logic        stale, too_soon, late, disc0, use_chip, poll_live, accept, reseed, fresh;
    logic        tick_valid, tick_disc, healthy;
    logic [31:0] tick_seconds, tick_edge_ms, cur_seconds;
    logic [9:0]  phase_ms;
    logic        is_start, tick_state, start_state;

    assign stale32   = {16'd0, i_cfg.stale_limit_ms};
    assign d_edge    = i_item.now_ms - i_item.edge_ms;
    assign d_last    = i_item.now_ms - r_last_edge_ms;
    assign d_start   = i_item.now_ms - r_start_ms;
    assign gap       = i_item.edge_ms - r_last_edge_ms;
    assign expected  = r_cached_seconds + 32'd1;

    assign stale     = d_edge >= stale32;
    assign too_soon  = r_saw_edge && (gap < {16'd0, i_cfg.min_gap_ms});
    assign late      = r_saw_edge && (gap > {16'd0, i_cfg.max_gap_ms});
    assign disc0     = r_resync_pending || !r_saw_edge || (i_item.pulse_count > 8'd1) || late;
    // expected second lands on a multiple of 30, zero after a wrap included
    assign use_chip  = disc0 || (r_cached_mod30 == pst_pkg::RESYNC_LAST) || (expected == 32'd0);
    assign poll_live = (i_item.op == pst_pkg::OP_POLL) && (i_item.pulse_count != 8'd0)
                       && !stale && !too_soon;
    assign accept    = poll_live && !(use_chip && i_item.edge_moved);
    assign reseed    = (i_item.op == pst_pkg::OP_START)
                       || ((i_item.op == pst_pkg::OP_SYNC) && i_cfg.device_present);

    always_comb begin
        n_cached_seconds = r_cached_seconds;
        n_cached_mod30   = r_cached_mod30;
        n_cache_valid    = r_cache_valid;
        n_resync_pending = r_resync_pending;
        n_saw_edge       = r_saw_edge;
        n_last_edge_ms   = r_last_edge_ms;
        n_start_ms       = r_start_ms;
        n_started        = r_started;
        tick_valid       = 1'b0;
        tick_seconds     = 32'd0;
        tick_edge_ms     = 32'd0;
        tick_disc        = 1'b0;
        unique case (i_item.op)
            pst_pkg::OP_START: begin
                n_start_ms       = i_item.now_ms;
                n_saw_edge       = 1'b0;
                n_started        = 1'b1;
                n_resync_pending = 1'b1;
                n_cached_seconds = i_item.chip_seconds;
                n_cached_mod30   = i_item.chip_mod30;
                n_cache_valid    = 1'b1;
            end
            pst_pkg::OP_SYNC: begin
                if (i_cfg.device_present) begin
                    n_cached_seconds = i_item.chip_seconds;
                    n_cached_mod30   = i_item.chip_mod30;
                    n_cache_valid    = 1'b1;
                    n_resync_pending = 1'b1;
                    n_saw_edge       = 1'b0;
                    n_start_ms       = i_item.now_ms;
                end
            end
            pst_pkg::OP_POLL: begin
                if (i_item.pulse_count != 8'd0) begin
                    if (stale || (poll_live && !accept)) begin
                        n_resync_pending = 1'b1;
                    end else if (accept) begin
                        n_cached_seconds = use_chip ? i_item.chip_seconds : expected;
                        if (use_chip) begin
                            n_cached_mod30 = i_item.chip_mod30;
                        end else begin
                            n_cached_mod30 = r_cached_mod30 + 5'd1;
                        end
                        n_cache_valid    = 1'b1;
                        n_resync_pending = 1'b0;
                        n_saw_edge       = 1'b1;
                        n_last_edge_ms   = i_item.edge_ms;
                        tick_valid       = 1'b1;
                        tick_seconds     = n_cached_seconds;
                        tick_edge_ms     = i_item.edge_ms;
                        tick_disc        = disc0
                            || (use_chip && (i_item.chip_seconds != expected));
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // age against the post-update reference, picked from precomputed differences
    always_comb begin
        if (n_saw_edge) begin
            d_ref = accept ? d_edge : d_last;
        end else begin
            d_ref = reseed ? 32'd0 : d_start;
        end
    end

    assign elapsed = accept ? d_edge : d_last;
    assign fresh   = n_started && (d_ref < stale32);

    always_comb begin
        if (!n_saw_edge || !fresh) begin
            phase_ms = i_item.now_mod1000;
        end else if (elapsed > {22'd0, pst_pkg::PHASE_CLAMP}) begin
            phase_ms = pst_pkg::PHASE_CLAMP;
        end else begin
            phase_ms = elapsed[9:0];
        end
    end

    assign healthy = i_cfg.device_present && (!n_started || fresh);

    always_comb begin
        if (!i_cfg.device_present) begin
            cur_seconds = pst_pkg::FALLBACK_SECONDS;
        end else if (!n_cache_valid || !fresh) begin
            cur_seconds = i_item.chip_seconds;
        end else begin
            cur_seconds = n_cached_seconds;
        end
    end

    assign o_res = {tick_valid, tick_seconds, tick_edge_ms, tick_disc,
                    phase_ms, healthy, cur_seconds};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached_seconds <= 32'd0;
            r_cached_mod30   <= 5'd0;
            r_cache_valid    <= 1'b0;
            r_resync_pending <= 1'b1;
            r_saw_edge       <= 1'b0;
            r_last_edge_ms   <= 32'd0;
            r_start_ms       <= 32'd0;
            r_started        <= 1'b0;
        end else if (i_advance) begin
            r_cached_seconds <= n_cached_seconds;
            r_cached_mod30   <= n_cached_mod30;
            r_cache_valid    <= n_cache_valid;
            r_resync_pending <= n_resync_pending;
            r_saw_edge       <= n_saw_edge;
            r_last_edge_ms   <= n_last_edge_ms;
            r_start_ms       <= n_start_ms;
            r_started        <= n_started;
        end
    end

    assign is_start    = i_item.op == pst_pkg::OP_START;
    assign tick_state  = r_saw_edge && r_cache_valid && !r_resync_pending;
    assign start_state = r_started && r_resync_pending && !r_saw_edge;

    `ASSERT_RST(a_mod30_range, i_clk, i_rst_n, r_cached_mod30 <= pst_pkg::RESYNC_LAST)
    `ASSERT_RST(a_tick_sets_state, i_clk, i_rst_n, (i_advance && tick_valid) |=> tick_state)
    `ASSERT_RST(a_start_marks, i_clk, i_rst_n, (i_advance && is_start) |=> start_state)
    `ASSERT_ALWAYS(a_tick_edge, i_clk, tick_valid |-> (tick_edge_ms == n_last_edge_ms))

endmodule

FILE: rtl/pps_second_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_second_tracker
// time-of-day tracker driven by one-pulse-per-second edges and a time chip
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result side is not stalled and returns
// exactly one result beat for each; a beat first lands in the input register,
// where now_ms mod 1000 and chip_seconds mod 30 are formed, then one pass of
// update logic writes the tracker state and the result register at the same
// edge, so the next beat always sees the state the previous one left. Both
// registers hold while the result side stalls, and input ready drops only
// when both are full and the result is not being taken. The user must write
// configuration registers through the plain write port only while no beat
// is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module pps_second_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_pulse_count,
    input  logic [31:0] i_edge_ms,
    input  logic [31:0] i_chip_seconds,
    input  logic        i_edge_moved,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tick_valid,
    output logic [31:0] o_tick_seconds,
    output logic [31:0] o_tick_edge_ms,
    output logic        o_discontinuity,
    output logic [9:0]  o_phase_ms,
    output logic        o_healthy,
    output logic [31:0] o_current_seconds
);

    pst_pkg::t_cfg    r_cfg;
    pst_pkg::t_item   r_a_item;
    logic             r_a_valid;
    pst_pkg::t_result r_b_res;
    logic             r_b_valid;
    pst_pkg::t_result res;
    logic             b_free, advance, a_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_present <= 1'b0;
            r_cfg.stale_limit_ms <= pst_pkg::STALE_LIMIT_RESET;
            r_cfg.min_gap_ms     <= pst_pkg::MIN_GAP_RESET;
            r_cfg.max_gap_ms     <= pst_pkg::MAX_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pst_pkg::REG_DEVICE_PRESENT: r_cfg.device_present <= i_cfg_data[0];
                pst_pkg::REG_STALE_LIMIT:    r_cfg.stale_limit_ms <= i_cfg_data;
                pst_pkg::REG_MIN_GAP:        r_cfg.min_gap_ms     <= i_cfg_data;
                pst_pkg::REG_MAX_GAP:        r_cfg.max_gap_ms     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign b_free     = !r_b_valid || i_out_ready;
    assign advance    = r_a_valid && b_free;
    assign o_in_ready = !r_a_valid || advance;
    assign a_load     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_load) begin
                r_a_valid <= 1'b1;
            end else if (advance) begin
                r_a_valid <= 1'b0;
            end
            if (advance) begin
                r_b_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_item.op           <= i_op;
            r_a_item.now_ms       <= i_now_ms;
            r_a_item.pulse_count  <= i_pulse_count;
            r_a_item.edge_ms      <= i_edge_ms;
            r_a_item.chip_seconds <= i_chip_seconds;
            r_a_item.edge_moved   <= i_edge_moved;
            r_a_item.now_mod1000  <= pst_pkg::mod1000(i_now_ms);
            r_a_item.chip_mod30   <= pst_pkg::mod30(i_chip_seconds);
        end
        if (advance) begin
            r_b_res <= res;
        end
    end

    pst_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_cfg    (r_cfg),
        .i_item   (r_a_item),
        .o_res    (res)
    );

    assign o_out_valid       = r_b_valid;
    assign o_tick_valid      = r_b_res.tick_valid;
    assign o_tick_seconds    = r_b_res.tick_seconds;
    assign o_tick_edge_ms    = r_b_res.tick_edge_ms;
    assign o_discontinuity   = r_b_res.discontinuity;
    assign o_phase_ms        = r_b_res.phase_ms;
    assign o_healthy         = r_b_res.healthy;
    assign o_current_seconds = r_b_res.current_seconds;

    `ASSERT_RST(a_result_kept, i_clk, i_rst_n, (r_b_valid && !i_out_ready) |=> r_b_valid)
    `ASSERT_RST(a_item_kept, i_clk, i_rst_n, (r_a_valid && !advance) |=> r_a_valid)
    `ASSERT_RST(a_ready_when_empty, i_clk, i_rst_n, !r_a_valid |-> o_in_ready)

endmodule
